[rtl/mpoc_pkg.sv]
`timescale 1ns / 1ps

package mpoc_pkg;

  localparam int SLOTS          = 4;
  localparam int BYTE_W         = 8;
  localparam int WORD_W         = 64;
  localparam int LEN_W          = 4;
  localparam int OUT_CNT_W      = 32;
  localparam int CNT_HOLD_W     = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int OUT_FIELDS_W   = SLOTS + SLOTS * OUT_CNT_W;
  localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int DEF_PATTERNS        = 4;
  localparam int DEF_MAX_PATTERN_LEN = 8;
  localparam int DEF_LINE_MAX        = 1024;
  localparam int DEF_COUNT_WIDTH     = 32;

  localparam logic [BYTE_W-1:0] NEWLINE   = 8'h0a;
  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

  localparam logic [CFG_IDX_W-1:0] REG_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_0  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_1  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_2  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_3  = 3'd7;

endpackage

[rtl/multi_pattern_overlap_counter.sv]
`timescale 1ns / 1ps

// Counts overlapping occurrences of up to four byte patterns (1 to 8 bytes each) in a
// byte stream. One text item is accepted per cycle, sustained unless m_tready stalls;
// its result item, carrying the hit mask and all counts after that byte, goes from the
// input register through one pass of the parallel byte comparators, which sets the rate,
// to the result register. Matches never cross a segment, which ends after a newline or
// after LINE_MAX bytes; a zero byte suppresses matches until its segment ends. Counts
// saturate at all ones; the low 32 bits are reported. The user must write pattern
// registers via cfg_we/cfg_index/cfg_data only while the stream is idle (not enforced).

module multi_pattern_overlap_counter import mpoc_pkg::*; #(
  parameter int PATTERNS        = DEF_PATTERNS,
  parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN,
  parameter int LINE_MAX        = DEF_LINE_MAX,
  parameter int COUNT_WIDTH     = DEF_COUNT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [7:0] text_byte
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [3:0] hit_mask, [35:4] count_0, [67:36] count_1, [99:68] count_2,
  // [131:100] count_3, [135:132] zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int FILL_W = $clog2(MAX_PATTERN_LEN + 1);
  localparam int POS_W  = $clog2(LINE_MAX);

  logic [SLOTS-1:0][WORD_W-1:0] pattern_word;
  logic [SLOTS-1:0][LEN_W-1:0]  pattern_len;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;

  logic [MAX_PATTERN_LEN-1:0][BYTE_W-1:0] window;
  logic [MAX_PATTERN_LEN-1:0][BYTE_W-1:0] window_next;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [POS_W-1:0]  seg_pos;
  logic              zero_seen;
  logic              zero_next;
  logic              seg_end;

  logic [SLOTS-1:0]  raw_hit;
  logic [SLOTS-1:0]  hit_next;
  logic [SLOTS-1:0]  cnt_nonzero;
  logic [SLOTS-1:0][OUT_CNT_W-1:0] cnt_out_next;

  logic [SLOTS-1:0]                out_hit;
  logic [SLOTS-1:0][OUT_CNT_W-1:0] out_cnt;

  logic advance;
  logic step;

  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_word <= '0;
      pattern_len  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WORD_0: pattern_word[0] <= cfg_data[WORD_W-1:0];
        REG_WORD_1: pattern_word[1] <= cfg_data[WORD_W-1:0];
        REG_WORD_2: pattern_word[2] <= cfg_data[WORD_W-1:0];
        REG_WORD_3: pattern_word[3] <= cfg_data[WORD_W-1:0];
        REG_LEN_0:  pattern_len[0]  <= cfg_data[LEN_W-1:0];
        REG_LEN_1:  pattern_len[1]  <= cfg_data[LEN_W-1:0];
        REG_LEN_2:  pattern_len[2]  <= cfg_data[LEN_W-1:0];
        REG_LEN_3:  pattern_len[3]  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // shift the new byte in at the newest end
  always_comb begin
    window_next[0] = in_byte;
    for (int i = 1; i < MAX_PATTERN_LEN; i++) begin
      window_next[i] = window[i-1];
    end
  end

  assign fill_next = (fill < FILL_W'(MAX_PATTERN_LEN)) ? fill + FILL_W'(1) : fill;
  assign zero_next = zero_seen || (in_byte == ZERO_BYTE);
  assign seg_end   = (in_byte == NEWLINE) || (seg_pos == POS_W'(LINE_MAX - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= '0;
      fill      <= '0;
      seg_pos   <= '0;
      zero_seen <= 1'b0;
    end else if (step) begin
      if (seg_end) begin
        window    <= '0;
        fill      <= '0;
        seg_pos   <= '0;
        zero_seen <= 1'b0;
      end else begin
        window    <= window_next;
        fill      <= fill_next;
        seg_pos   <= seg_pos + POS_W'(1);
        zero_seen <= zero_next;
      end
    end
  end

  for (genvar k = 0; k < SLOTS; k++) begin : g_slot
    if (k < PATTERNS) begin : g_used
      logic [COUNT_WIDTH-1:0] cnt;
      logic [COUNT_WIDTH-1:0] cnt_next;
      logic [CNT_HOLD_W-1:0]  cnt_ext;

      mpoc_matcher #(
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
        .FILL_W          (FILL_W)
      ) u_matcher (
        .window (window_next),
        .fill   (fill_next),
        .word   (pattern_word[k]),
        .len    (pattern_len[k]),
        .hit    (raw_hit[k])
      );

      assign hit_next[k] = raw_hit[k] && !zero_next;
      assign cnt_next    = (hit_next[k] && cnt != '1) ? cnt + COUNT_WIDTH'(1) : cnt;
      assign cnt_ext     = CNT_HOLD_W'(cnt_next);
      assign cnt_out_next[k] = cnt_ext[OUT_CNT_W-1:0];
      assign cnt_nonzero[k]  = (cnt != '0);

      always_ff @(posedge clk) begin
        if (rst) begin
          cnt <= '0;
        end else if (step) begin
          cnt <= cnt_next;
        end
      end
    end else begin : g_unused
      assign raw_hit[k]      = 1'b0;
      assign hit_next[k]     = 1'b0;
      assign cnt_out_next[k] = '0;
      assign cnt_nonzero[k]  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_hit <= hit_next;
      out_cnt <= cnt_out_next;
    end
  end

  assign m_tdata = OUT_TDATA_W'({out_cnt, out_hit});

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(MAX_PATTERN_LEN))
    else $error("window fill exceeds pattern length limit");

  a_newline_clears: assert property (@(posedge clk) disable iff (rst)
    (step && in_byte == NEWLINE) |=> (fill == '0 && !zero_seen && seg_pos == '0))
    else $error("segment state not cleared after newline");

  a_zero_blocks: assert property (@(posedge clk) disable iff (rst)
    (step && zero_next) |=> (out_hit == '0))
    else $error("hit reported after zero byte in segment");

  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    step |=> ((out_hit & ~cnt_nonzero) == '0))
    else $error("hit reported while its count is zero");

  a_step_delivers: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("processed item produced no result");

endmodule

[rtl/mpoc_matcher.sv]
`timescale 1ns / 1ps

module mpoc_matcher import mpoc_pkg::*; #(
  parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN,
  parameter int FILL_W          = $clog2(DEF_MAX_PATTERN_LEN + 1)
) (
  input  logic [MAX_PATTERN_LEN-1:0][BYTE_W-1:0] window,
  input  logic [FILL_W-1:0]                      fill,
  input  logic [WORD_W-1:0]                      word,
  input  logic [LEN_W-1:0]                       len,
  output logic                                   hit
);

  logic [MAX_PATTERN_LEN:1] len_ok;

  // window[0] is the newest byte and lines up with the last pattern byte
  always_comb begin
    for (int l = 1; l <= MAX_PATTERN_LEN; l++) begin
      len_ok[l] = 1'b1;
      for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
        if (i < l) begin
          len_ok[l] = len_ok[l] & (window[i] == word[BYTE_W*(l-1-i) +: BYTE_W]);
        end
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int l = 1; l <= MAX_PATTERN_LEN; l++) begin
      if (len == LEN_W'(l) && 32'(fill) >= 32'(l)) begin
        hit = len_ok[l];
      end
    end
  end

endmodule

[sim/tb_multi_pattern_overlap_counter.sv]
`timescale 1ns / 1ps

module tb_multi_pattern_overlap_counter;
  import mpoc_pkg::*;

  localparam int WIN_LEN     = DEF_MAX_PATTERN_LEN;
  localparam int SEG_LIMIT   = DEF_LINE_MAX;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PAD_W       = OUT_TDATA_W - OUT_FIELDS_W;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic [PAD_W-1:0]                pad;
    logic [SLOTS-1:0][OUT_CNT_W-1:0] cnt;
    logic [SLOTS-1:0]                hit;
  } result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_WORD_0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  multi_pattern_overlap_counter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  logic [WORD_W-1:0]    pat_word [SLOTS];
  logic [LEN_W-1:0]     pat_len [SLOTS];
  logic [BYTE_W-1:0]    win [WIN_LEN];
  int                   win_fill;
  int                   seg_pos;
  bit                   nul_seen;
  logic [OUT_CNT_W-1:0] hit_count [SLOTS];

  result_t           pending_results [$];
  logic [BYTE_W-1:0] text_fifo [$];
  bit                in_hold;
  bit                hold_off_req;
  int                hold_left;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                errors;
  int                cycles;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_segment();
    for (int i = 0; i < WIN_LEN; i++) win[i] = '0;
    win_fill = 0;
    seg_pos  = 0;
    nul_seen = 1'b0;
  endfunction

  function automatic result_t scan_byte(input logic [BYTE_W-1:0] b);
    result_t r;
    bit      hit_k;
    int      len;
    r = '0;
    for (int i = WIN_LEN - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = b;
    if (win_fill < WIN_LEN) win_fill++;
    if (b == ZERO_BYTE) nul_seen = 1'b1;
    for (int k = 0; k < SLOTS; k++) begin
      len   = pat_len[k];
      hit_k = !nul_seen && len != 0 && len <= WIN_LEN && len <= win_fill;
      if (hit_k) begin
        for (int j = 0; j < len; j++) begin
          if (win[len-1-j] != pat_word[k][8*j +: 8]) hit_k = 1'b0;
        end
      end
      if (hit_k) begin
        r.hit[k] = 1'b1;
        if (hit_count[k] != '1) hit_count[k]++;
      end
      r.cnt[k] = hit_count[k];
    end
    seg_pos++;
    if (b == NEWLINE || seg_pos >= SEG_LIMIT) clear_segment();
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    errors++;
    $display("%0t: %s expected %0h got %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else if (rst) begin
      for (int k = 0; k < SLOTS; k++) begin
        pat_word[k]  = '0;
        pat_len[k]   = '0;
        hit_count[k] = '0;
      end
      clear_segment();
    end else begin
      if (cfg_we) begin
        if (cfg_index <= REG_WORD_3) pat_word[cfg_index] = cfg_data;
        else pat_len[cfg_index - REG_LEN_0] = cfg_data[LEN_W-1:0];
      end
      if (s_tvalid && s_tready) begin
        pending_results.push_back(scan_byte(s_tdata));
        void'(text_fifo.pop_front());
        in_hold = 1'b0;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item %0h", $time, got);
        end else begin
          want = pending_results.pop_front();
          if (got.hit !== want.hit) report_mismatch("hit_mask", want.hit, got.hit);
          for (int k = 0; k < SLOTS; k++) begin
            if (got.cnt[k] !== want.cnt[k])
              report_mismatch($sformatf("count_%0d", k), want.cnt[k], got.cnt[k]);
          end
          if (got.pad !== want.pad) report_mismatch("pad", want.pad, got.pad);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!in_hold) begin
      if (!rst && text_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= text_fifo[0];
        in_hold = 1'b1;
      end else begin
        s_tvalid <= 1'b0;
        s_tdata  <= 8'($urandom);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left    = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [BYTE_W-1:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 72) return "a" + 8'($urandom_range(2));
    if (r < 79) return NEWLINE;
    if (r < 80) return ZERO_BYTE;
    return 8'($urandom);
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 18) return LEN_W'(9 + $urandom_range(6));
    if (r < 28) return LEN_W'(WIN_LEN);
    return LEN_W'(1 + $urandom_range(3));
  endfunction

  function automatic logic [WORD_W-1:0] make_word(input logic [LEN_W-1:0] n);
    logic [WORD_W-1:0] w;
    w = {$urandom, $urandom};
    for (int j = 0; j < n && j < WIN_LEN; j++) begin
      w[8*j +: 8] = ($urandom_range(19) == 0) ? NEWLINE : "a" + 8'($urandom_range(2));
    end
    return w;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic program_patterns(input logic [WORD_W-1:0] w [SLOTS],
                                  input logic [LEN_W-1:0] n [SLOTS]);
    logic [CFG_DATA_W-1:0] d;
    for (int k = 0; k < SLOTS; k++) write_reg(REG_WORD_0 + CFG_IDX_W'(k), w[k]);
    for (int k = 0; k < SLOTS; k++) begin
      d = {$urandom, $urandom};
      d[LEN_W-1:0] = n[k];
      write_reg(REG_LEN_0 + CFG_IDX_W'(k), d);
    end
  endtask

  task automatic drain(input int tail);
    while (text_fifo.size() != 0 || in_hold || pending_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  initial begin
    string             dir_text;
    logic [WORD_W-1:0] w [SLOTS];
    logic [LEN_W-1:0]  n [SLOTS];
    int                items;
    send_idle_pct = 6;
    recv_idle_pct = 46;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    w[0] = 64'h5a5a_0000_ff00_6161;
    w[1] = 64'h0000_0000_0000_0a62;
    w[2] = 64'h6867_6665_6463_6261;
    w[3] = 64'h6161_6161_6161_6161;
    n[0] = 4'd2;
    n[1] = 4'd2;
    n[2] = LEN_W'(WIN_LEN);
    n[3] = 4'd9;
    program_patterns(w, n);
    dir_text = "aaaa\nab\nabcdefgh";
    for (int i = 0; i < dir_text.len(); i++) text_fifo.push_back(dir_text[i]);
    text_fifo.push_back(ZERO_BYTE);
    text_fifo.push_back("a");
    text_fifo.push_back("a");
    text_fifo.push_back(NEWLINE);
    text_fifo.push_back("a");
    text_fifo.push_back("a");
    text_fifo.push_back(8'hff);

    for (int ph = 1; ph <= 7; ph++) begin
      drain(4);
      send_idle_pct = (ph <= 2) ? 6 : (ph <= 4) ? 46 : 0;
      recv_idle_pct = (ph <= 2) ? 46 : (ph <= 4) ? 6 : 0;
      items = 180;
      for (int k = 0; k < SLOTS; k++) begin
        n[k] = pick_len();
        w[k] = make_word(n[k]);
      end
      case (ph)
        1: begin
          for (int k = 0; k < SLOTS; k++) begin
            n[k] = 4'd1;
            w[k] = make_word(n[k]);
          end
        end
        4: begin
          items = 1040;
          w[0] = 64'h6161_6161_6161_6161;
          w[1] = make_word(4'd1);
          w[1][7:0] = "a";
          w[2] = {48'($urandom), 16'h6261};
          w[3] = {48'($urandom), 16'h6162};
          n[0] = LEN_W'(WIN_LEN);
          n[1] = 4'd1;
          n[2] = 4'd2;
          n[3] = 4'd2;
        end
        7: begin
          items = 60;
          n[0] = 4'd0;
          n[1] = 4'd9;
          n[2] = 4'd15;
          n[3] = 4'd12;
        end
        default: ;
      endcase
      program_patterns(w, n);
      for (int i = 0; i < items; i++) begin
        if (ph == 4) text_fifo.push_back(($urandom_range(99) < 85) ? "a" : "b");
        else text_fifo.push_back(pick_char());
      end
      if (ph == 4) text_fifo.push_back(NEWLINE);
      if (ph == 2) hold_off_req = 1'b1;
    end

    drain(10);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/mpoc_pkg.sv
rtl/mpoc_matcher.sv
rtl/multi_pattern_overlap_counter.sv
sim/tb_multi_pattern_overlap_counter.sv
